// ----- hw/rtl/frame_table_clock_replacement_defines.svh -----
// ----------------------------------------------------------------------------
// Frame table assertion macros
// Shared concurrent assertion forms for the frame table block.
// ----------------------------------------------------------------------------
`ifndef FRAME_TABLE_CLOCK_REPLACEMENT_DEFINES_SVH
`define FRAME_TABLE_CLOCK_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FTCR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FTCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ftcr_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame table package
// Sizes, operation codes, state type and transfer structs of the frame table.
// ----------------------------------------------------------------------------
package ftcr_pkg;

   localparam int MAX_FRAMES    = 64;
   localparam int PAGE_TAG_BITS = 20;
   localparam int FRAME_BITS    = $clog2(MAX_FRAMES);
   localparam int COUNT_BITS    = $clog2(MAX_FRAMES + 1);
   localparam int CSR_BITS      = 7;
   localparam int OP_BITS       = 2;

   localparam logic [OP_BITS-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REF     = 2'd1;
   localparam logic [OP_BITS-1:0] OP_RELEASE = 2'd2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP,
      ST_EVICT
   } state_type;

   typedef struct packed {
      logic [OP_BITS-1:0]       operation;
      logic [FRAME_BITS-1:0]    frame_index;
      logic [PAGE_TAG_BITS-1:0] page_tag;
      logic                     is_write;
      logic                     start_dirty;
   } req_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0]    granted_frame;
      logic                     evicted;
      logic [PAGE_TAG_BITS-1:0] victim_page;
      logic                     victim_dirty;
      logic                     status;
   } rsp_type;

   typedef struct packed {
      logic                     we;
      logic [FRAME_BITS-1:0]    waddr;
      logic [PAGE_TAG_BITS-1:0] wdata;
      logic [FRAME_BITS-1:0]    raddr;
   } mem_req_type;

endpackage

// ----- hw/rtl/ftcr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ftcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/ftcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// Frame table sequencer
// Holds the per-frame flag vectors and the clock hand, and walks one frame a
// cycle through the free scan and the second-chance sweep.
// ----------------------------------------------------------------------------
`include "frame_table_clock_replacement_defines.svh"

module ftcr_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  ftcr_pkg::req_type                   req,
   input  logic [ftcr_pkg::COUNT_BITS-1:0]     count,
   output logic                                busy,
   output logic                                rsp_strobe,
   output ftcr_pkg::rsp_type                   rsp,
   output ftcr_pkg::mem_req_type               mem_req,
   input  logic [ftcr_pkg::PAGE_TAG_BITS-1:0]  mem_rdata
);

   ftcr_pkg::state_type                    state_ff, state_in;
   logic [ftcr_pkg::MAX_FRAMES-1:0]        occ_ff, occ_in;
   logic [ftcr_pkg::MAX_FRAMES-1:0]        ref_ff, ref_in;
   logic [ftcr_pkg::MAX_FRAMES-1:0]        mod_ff, mod_in;
   logic [ftcr_pkg::FRAME_BITS-1:0]        hand_ff, hand_in;
   logic [ftcr_pkg::FRAME_BITS-1:0]        idx_ff, idx_in;
   ftcr_pkg::req_type                      req_ff, req_in;
   logic                                   strobe_ff, strobe_in;
   ftcr_pkg::rsp_type                      rsp_ff, rsp_in;

   logic [ftcr_pkg::COUNT_BITS-1:0]        idx_plus;
   logic [ftcr_pkg::FRAME_BITS-1:0]        idx_next;
   logic                                   req_ok;

   // Frame after the current one, wrapping at the frame count.
   assign idx_plus = ftcr_pkg::COUNT_BITS'(idx_ff) + ftcr_pkg::COUNT_BITS'(1);
   assign idx_next = (idx_plus >= count) ? '0 : ftcr_pkg::FRAME_BITS'(idx_plus);
   assign req_ok   = (ftcr_pkg::COUNT_BITS'(req.frame_index) < count) &&
                     occ_ff[req.frame_index];

   assign busy = (state_ff != ftcr_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ftcr_pkg::ST_IDLE;
         occ_ff    <= '0;
         ref_ff    <= '0;
         mod_ff    <= '0;
         hand_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         ref_ff    <= ref_in;
         mod_ff    <= mod_in;
         hand_ff   <= hand_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in        = state_ff;
      occ_in          = occ_ff;
      ref_in          = ref_ff;
      mod_in          = mod_ff;
      hand_in         = hand_ff;
      idx_in          = idx_ff;
      req_in          = req_ff;
      strobe_in       = 1'b0;
      rsp_in          = rsp_ff;
      mem_req.we      = 1'b0;
      mem_req.waddr   = idx_ff;
      mem_req.wdata   = req_ff.page_tag;
      mem_req.raddr   = idx_ff;

      case (state_ff)
         ftcr_pkg::ST_IDLE: begin
            if (start) begin
               req_in               = req;
               rsp_in.granted_frame = req.frame_index;
               rsp_in.evicted       = 1'b0;
               rsp_in.victim_page   = '0;
               rsp_in.victim_dirty  = 1'b0;
               rsp_in.status        = ftcr_pkg::STATUS_OK;
               case (req.operation)
                  ftcr_pkg::OP_ALLOC: begin
                     idx_in   = '0;
                     state_in = ftcr_pkg::ST_SCAN;
                  end
                  ftcr_pkg::OP_REF: begin
                     strobe_in = 1'b1;
                     if (req_ok) begin
                        ref_in[req.frame_index] = 1'b1;
                        if (req.is_write) begin
                           mod_in[req.frame_index] = 1'b1;
                        end
                     end else begin
                        rsp_in.status = ftcr_pkg::STATUS_ERR;
                     end
                  end
                  ftcr_pkg::OP_RELEASE: begin
                     strobe_in = 1'b1;
                     if (req_ok) begin
                        occ_in[req.frame_index] = 1'b0;
                        ref_in[req.frame_index] = 1'b0;
                        mod_in[req.frame_index] = 1'b0;
                     end else begin
                        rsp_in.status = ftcr_pkg::STATUS_ERR;
                     end
                  end
                  default: begin
                     strobe_in     = 1'b1;
                     rsp_in.status = ftcr_pkg::STATUS_ERR;
                  end
               endcase
            end
         end
         ftcr_pkg::ST_SCAN: begin
            if (!occ_ff[idx_ff]) begin
               mem_req.we           = 1'b1;
               occ_in[idx_ff]       = 1'b1;
               ref_in[idx_ff]       = 1'b1;
               mod_in[idx_ff]       = req_ff.start_dirty;
               rsp_in.granted_frame = idx_ff;
               strobe_in            = 1'b1;
               state_in             = ftcr_pkg::ST_IDLE;
            end else if (idx_plus == count) begin
               // Every frame in use is taken; the sweep starts at the hand,
               // or at frame zero when the count shrank below it.
               idx_in   = (ftcr_pkg::COUNT_BITS'(hand_ff) >= count) ? '0 : hand_ff;
               state_in = ftcr_pkg::ST_SWEEP;
            end else begin
               idx_in = ftcr_pkg::FRAME_BITS'(idx_plus);
            end
         end
         ftcr_pkg::ST_SWEEP: begin
            if (ref_ff[idx_ff]) begin
               ref_in[idx_ff] = 1'b0;
               idx_in         = idx_next;
            end else begin
               // The victim's tag is read this cycle and arrives next cycle.
               hand_in  = idx_next;
               state_in = ftcr_pkg::ST_EVICT;
            end
         end
         ftcr_pkg::ST_EVICT: begin
            mem_req.we           = 1'b1;
            occ_in[idx_ff]       = 1'b1;
            ref_in[idx_ff]       = 1'b1;
            mod_in[idx_ff]       = req_ff.start_dirty;
            rsp_in.granted_frame = idx_ff;
            rsp_in.evicted       = 1'b1;
            rsp_in.victim_page   = mem_rdata;
            rsp_in.victim_dirty  = mod_ff[idx_ff];
            strobe_in            = 1'b1;
            state_in             = ftcr_pkg::ST_IDLE;
         end
         default: begin
            state_in = ftcr_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   `FTCR_ASSERT_NOW(a_scan_in_range, clock, reset,
      state_ff == ftcr_pkg::ST_SCAN || state_ff == ftcr_pkg::ST_SWEEP,
      ftcr_pkg::COUNT_BITS'(idx_ff) < count, "frame walk left the frames in use")
   `FTCR_ASSERT_NEXT(a_evict_reports, clock, reset,
      state_ff == ftcr_pkg::ST_EVICT,
      rsp_strobe && rsp.evicted && rsp.status == ftcr_pkg::STATUS_OK,
      "eviction did not produce an evicting transfer")
   `FTCR_ASSERT_NEXT(a_alloc_goes_busy, clock, reset,
      start && !busy && req.operation == ftcr_pkg::OP_ALLOC,
      busy && !rsp_strobe, "allocate did not start the frame scan")
   `FTCR_ASSERT_NOW(a_granted_occupied, clock, reset,
      rsp_strobe && $past(busy), occ_ff[rsp.granted_frame] && ref_ff[rsp.granted_frame],
      "granted frame is not marked occupied and referenced")

endmodule

// ----- hw/rtl/frame_table_clock_replacement.sv -----
// ----------------------------------------------------------------------------
// Frame table with clock replacement
// Physical frame table that hands out free frames and, when all are taken,
// evicts with a second-chance clock sweep.
//
//   Channel   Ports                        Transfer
//   request   start, busy, req_data        start high and busy low at a clock edge
//   response  rsp_strobe, rsp_data         strobe high for exactly one cycle
//   register  csr_we, csr_wdata            csr_we high at a clock edge
//
// Reference, release and unknown operations answer on the next cycle and leave
// busy low. An allocate scans up from frame zero for the first free frame; with
// every frame in use it scans them all, sweeps from the hand clearing set
// reference flags until it meets an unreferenced frame and reads that frame's
// tag. The walk covers one frame index per cycle over the flag vectors.
// Synchronous reset frees every frame, parks the hand at zero and sets the
// frame count to its maximum; no clearing pass follows. The receiver cannot
// stall, so a response is never held back.
// ----------------------------------------------------------------------------
module frame_table_clock_replacement (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ftcr_pkg::req_type                 req_data,
   output logic                              rsp_strobe,
   output ftcr_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [ftcr_pkg::CSR_BITS-1:0]     csr_wdata
);

   logic [ftcr_pkg::CSR_BITS-1:0]       csr_ff, csr_in;
   logic [ftcr_pkg::COUNT_BITS-1:0]     count;
   ftcr_pkg::mem_req_type               mem_req;
   logic [ftcr_pkg::PAGE_TAG_BITS-1:0]  mem_rdata;

   assign csr_in = csr_we ? csr_wdata : csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= ftcr_pkg::CSR_BITS'(ftcr_pkg::MAX_FRAMES);
      end else begin
         csr_ff <= csr_in;
      end
   end

   // The register is saturated into the range of one frame to all frames.
   always_comb begin
      if (csr_ff == '0) begin
         count = ftcr_pkg::COUNT_BITS'(1);
      end else if (int'(csr_ff) > ftcr_pkg::MAX_FRAMES) begin
         count = ftcr_pkg::COUNT_BITS'(ftcr_pkg::MAX_FRAMES);
      end else begin
         count = ftcr_pkg::COUNT_BITS'(csr_ff);
      end
   end

   ftcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_data),
      .count      (count),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata)
   );

   ftcr_ram #(
      .WIDTH (ftcr_pkg::PAGE_TAG_BITS),
      .DEPTH (ftcr_pkg::MAX_FRAMES)
   ) u_tag_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

endmodule

// ----- bench/frame_table_clock_replacement_tb.sv -----
// ----------------------------------------------------------------------------
// Frame table clock replacement testbench
// Drives allocate, reference, release and illegal requests under several frame
// counts, predicts every response with an in-bench frame table model and checks
// each response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_table_clock_replacement_tb;

   import ftcr_pkg::*;

   localparam int IDLE_PCT = 19;

   // Operation code that the block does not implement.
   localparam logic [OP_BITS-1:0] OP_UNKNOWN = 2'd3;

   class frame_table_scoreboard;
      bit                       occ   [MAX_FRAMES];
      bit                       refd  [MAX_FRAMES];
      bit                       dirty [MAX_FRAMES];
      logic [PAGE_TAG_BITS-1:0] tags  [MAX_FRAMES];
      int unsigned              hand;
      logic [CSR_BITS-1:0]      frames_cfg;
      rsp_type                  expected_rsp_q[$];
      int unsigned              failures;

      function new();
         for (int i = 0; i < MAX_FRAMES; i++) begin
            occ[i]   = 1'b0;
            refd[i]  = 1'b0;
            dirty[i] = 1'b0;
            tags[i]  = '0;
         end
         hand       = 0;
         frames_cfg = CSR_BITS'(MAX_FRAMES);
         failures   = 0;
      endfunction

      function void set_frames(logic [CSR_BITS-1:0] value);
         frames_cfg = value;
      endfunction

      // The register value is saturated into 1..MAX_FRAMES.
      function int unsigned active_frames();
         if (frames_cfg < 1) return 1;
         if (frames_cfg > MAX_FRAMES) return MAX_FRAMES;
         return frames_cfg;
      endfunction

      function int unsigned pending();
         return expected_rsp_q.size();
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         int unsigned n, f, h, cur, step, i;
         bit          found;
         n               = active_frames();
         e               = '0;
         e.granted_frame = r.frame_index;
         e.status        = STATUS_OK;
         case (r.operation)
            OP_ALLOC: begin
               found = 1'b0;
               f     = 0;
               for (i = 0; i < n && !found; i++) begin
                  if (!occ[i]) begin
                     f     = i;
                     found = 1'b1;
                  end
               end
               if (!found) begin
                  // Second-chance sweep; a hand left beyond a shrunk count restarts at zero.
                  h = (hand >= n) ? 0 : hand;
                  f = h;
                  for (step = 0; step < 2 * n && !found; step++) begin
                     cur = h;
                     h   = (h + 1 >= n) ? 0 : h + 1;
                     if (refd[cur]) begin
                        refd[cur] = 1'b0;
                     end else begin
                        f     = cur;
                        found = 1'b1;
                     end
                  end
                  hand           = h;
                  e.evicted      = 1'b1;
                  e.victim_page  = tags[f];
                  e.victim_dirty = dirty[f];
               end
               occ[f]          = 1'b1;
               refd[f]         = 1'b1;
               dirty[f]        = r.start_dirty;
               tags[f]         = r.page_tag;
               e.granted_frame = FRAME_BITS'(f);
            end
            OP_REF: begin
               if (r.frame_index < n && occ[r.frame_index]) begin
                  refd[r.frame_index] = 1'b1;
                  if (r.is_write) dirty[r.frame_index] = 1'b1;
               end else begin
                  e.status = STATUS_ERR;
               end
            end
            OP_RELEASE: begin
               if (r.frame_index < n && occ[r.frame_index]) begin
                  occ[r.frame_index]   = 1'b0;
                  refd[r.frame_index]  = 1'b0;
                  dirty[r.frame_index] = 1'b0;
               end else begin
                  e.status = STATUS_ERR;
               end
            end
            default: begin
               e.status = STATUS_ERR;
            end
         endcase
         expected_rsp_q.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_rsp_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("ERROR: unexpected response frame=%0d evicted=%0b page=%h",
                        got.granted_frame, got.evicted, got.victim_page,
                        " dirty=%0b status=%0b", got.victim_dirty, got.status);
            return;
         end
         e = expected_rsp_q.pop_front();
         if (got.granted_frame !== e.granted_frame || got.evicted !== e.evicted ||
             got.victim_page !== e.victim_page || got.victim_dirty !== e.victim_dirty ||
             got.status !== e.status) begin
            failures++;
            if (failures <= 10)
               $display("ERROR: mismatch: expected frame=%0d evicted=%0b page=%h dirty=%0b",
                        e.granted_frame, e.evicted, e.victim_page, e.victim_dirty,
                        " status=%0b, got frame=%0d evicted=%0b page=%h dirty=%0b",
                        e.status, got.granted_frame, got.evicted, got.victim_page,
                        got.victim_dirty, " status=%0b", got.status);
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_strobe;
   rsp_type             rsp_data;
   logic                csr_we;
   logic [CSR_BITS-1:0] csr_wdata;

   frame_table_scoreboard sb;

   frame_table_clock_replacement dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_response(rsp_data);
   end

   function automatic req_type make_request(logic [OP_BITS-1:0] op, int unsigned idx,
                                            logic [PAGE_TAG_BITS-1:0] tag, bit wr, bit sd);
      req_type r;
      r.operation   = op;
      r.frame_index = FRAME_BITS'(idx);
      r.page_tag    = tag;
      r.is_write    = wr;
      r.start_dirty = sd;
      return r;
   endfunction

   // Mostly legal operations on frames inside the count, with some stray indexes
   // and an occasional illegal operation code.
   function automatic req_type random_request(int unsigned n);
      req_type     r;
      int unsigned pick;
      r.page_tag    = PAGE_TAG_BITS'($urandom);
      r.is_write    = 1'($urandom_range(1));
      r.start_dirty = 1'($urandom_range(1));
      r.frame_index = ($urandom_range(99) < 80) ? FRAME_BITS'($urandom_range(n - 1))
                                                : FRAME_BITS'($urandom);
      pick = $urandom_range(99);
      if (pick < 40)      r.operation = OP_ALLOC;
      else if (pick < 75) r.operation = OP_REF;
      else if (pick < 95) r.operation = OP_RELEASE;
      else                r.operation = OP_UNKNOWN;
      return r;
   endfunction

   // Entered at a falling edge; returns at the falling edge after the transfer with
   // start still high, so the caller either sends again or lowers start.
   task automatic send_request(input req_type r, input bit allow_gaps);
      if (allow_gaps && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic program_frames(input logic [CSR_BITS-1:0] value);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_frames(value);
   endtask

   task automatic run_phase(input logic [CSR_BITS-1:0] frames, input int unsigned count,
                            input bit allow_gaps);
      program_frames(frames);
      repeat (count) send_request(random_request(sb.active_frames()), allow_gaps);
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      sb        = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Full frame count out of reset: errors on free frames, an illegal code,
      // then fill the low frames.
      send_request(make_request(OP_REF, 0, 20'h12345, 1'b1, 1'b0), 1'b1);
      send_request(make_request(OP_RELEASE, 63, 20'h0, 1'b0, 1'b0), 1'b1);
      send_request(make_request(OP_UNKNOWN, 63, 20'hFFFFF, 1'b1, 1'b1), 1'b1);
      send_request(make_request(OP_ALLOC, 0, 20'hFFFFF, 1'b0, 1'b1), 1'b1);
      send_request(make_request(OP_ALLOC, 63, 20'h00000, 1'b1, 1'b0), 1'b1);
      send_request(make_request(OP_ALLOC, 0, 20'hA5A5A, 1'b0, 1'b0), 1'b1);
      send_request(make_request(OP_ALLOC, 0, 20'h5A5A5, 1'b0, 1'b1), 1'b1);
      send_request(make_request(OP_REF, 2, 20'h0, 1'b1, 1'b0), 1'b1);
      send_request(make_request(OP_RELEASE, 1, 20'h0, 1'b0, 1'b0), 1'b1);
      send_request(make_request(OP_REF, 1, 20'h0, 1'b0, 1'b0), 1'b1);
      send_request(make_request(OP_ALLOC, 5, 20'h0F0F0, 1'b0, 1'b0), 1'b1);

      // A count of zero acts as one frame; frames above it are out of reach.
      program_frames('0);
      send_request(make_request(OP_REF, 3, 20'h0, 1'b1, 1'b0), 1'b1);
      send_request(make_request(OP_RELEASE, 63, 20'h0, 1'b0, 1'b0), 1'b1);
      send_request(make_request(OP_ALLOC, 0, 20'h11111, 1'b0, 1'b1), 1'b1);

      // Four full frames: every one referenced, so the sweep clears them all first.
      program_frames(7'd4);
      send_request(make_request(OP_ALLOC, 0, 20'h22222, 1'b0, 1'b0), 1'b1);
      send_request(make_request(OP_ALLOC, 0, 20'h33333, 1'b0, 1'b1), 1'b1);
      send_request(make_request(OP_ALLOC, 0, 20'h44444, 1'b0, 1'b0), 1'b1);

      // The hand now sits beyond the shrunk count and must restart at frame zero.
      program_frames(7'd2);
      send_request(make_request(OP_ALLOC, 0, 20'h55555, 1'b0, 1'b1), 1'b1);
      send_request(make_request(OP_REF, 3, 20'h0, 1'b0, 1'b0), 1'b1);

      // Above the maximum saturates to all frames.
      program_frames(7'd127);
      send_request(make_request(OP_ALLOC, 0, 20'h66666, 1'b0, 1'b0), 1'b1);
      send_request(make_request(OP_REF, 63, 20'h0, 1'b1, 1'b0), 1'b1);
      send_request(make_request(OP_RELEASE, 0, 20'h0, 1'b0, 1'b0), 1'b1);
      send_request(make_request(OP_RELEASE, 3, 20'h0, 1'b0, 1'b0), 1'b1);

      run_phase(7'd8, 100, 1'b1);
      run_phase(7'd64, 60, 1'b1);
      run_phase(7'd3, 90, 1'b1);
      run_phase(7'd16, 120, 1'b0);
      run_phase(CSR_BITS'($urandom_range(1, 127)), 130, 1'b1);
      start <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * MAX_FRAMES + 4) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("PASS frame_table_clock_replacement");
      end else begin
         $display("FAIL frame_table_clock_replacement");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL frame_table_clock_replacement");
      $finish;
   end

endmodule
